[rtl/xdl_pkg.sv]
// Package for the xor-distance lookup shortlist.
// Holds the entry type, status and action codes and register indexes.
// No dependencies.
`default_nettype none

package xdl_pkg;

    localparam int TableDepth = 32;

    // action codes
    localparam logic [1:0] ACT_ADD  = 2'd0;
    localparam logic [1:0] ACT_GET  = 2'd1;
    localparam logic [1:0] ACT_REP  = 2'd2;
    localparam logic [1:0] ACT_TRIM = 2'd3;

    // result status codes
    localparam logic [2:0] STS_OK       = 3'd0;
    localparam logic [2:0] STS_DUP      = 3'd1;
    localparam logic [2:0] STS_FULL     = 3'd2;
    localparam logic [2:0] STS_CONC     = 3'd3;
    localparam logic [2:0] STS_NONE     = 3'd4;
    localparam logic [2:0] STS_NOT_ACT  = 3'd5;

    // entry status bits
    localparam int BIT_ACTIVE = 0;
    localparam int BIT_GOOD   = 1;
    localparam int BIT_BAD    = 2;

    // configuration register indexes
    localparam logic [2:0] CFG_TGT_HI   = 3'd0;
    localparam logic [2:0] CFG_TGT_MID  = 3'd1;
    localparam logic [2:0] CFG_TGT_LO   = 3'd2;
    localparam logic [2:0] CFG_CONC     = 3'd3;
    localparam logic [2:0] CFG_CLOSEST  = 3'd4;
    localparam logic [2:0] CFG_ANN_MODE = 3'd5;
    localparam logic [2:0] CFG_ANN_KEEP = 3'd6;

    // 160-bit id
    typedef struct packed {
        logic [63:0] hi;
        logic [63:0] mid;
        logic [31:0] lo;
    } t_id;

    // one shortlist entry
    typedef struct packed {
        t_id         key;
        logic [47:0] addr;
        logic [2:0]  st;
    } t_entry;

endpackage

`default_nettype wire

[rtl/xdl_cmp.sv]
// Shared distance compare unit: xor distance order and id equality.
// Depends on xdl_pkg.
`default_nettype none

module xdl_cmp (
    input  wire xdl_pkg::t_id i_a,
    input  wire xdl_pkg::t_id i_b,
    input  wire xdl_pkg::t_id i_target,
    output logic              o_closer,
    output logic              o_equal
);

    logic [159:0] dist_a;
    logic [159:0] dist_b;

    // distance as one unsigned 160-bit number
    assign dist_a   = i_a ^ i_target;
    assign dist_b   = i_b ^ i_target;
    assign o_closer = dist_a < dist_b;
    assign o_equal  = i_a == i_b;

endmodule

`default_nettype wire

[rtl/xdl_mem.sv]
// Entry memory of the shortlist: one write port, one registered read port.
// Depends on xdl_pkg.
`default_nettype none

module xdl_mem #(
    parameter int DEPTH = xdl_pkg::TableDepth
) (
    input  wire                          i_clk,
    input  wire                          i_we,
    input  wire  [$clog2(DEPTH)-1:0]     i_waddr,
    input  wire  xdl_pkg::t_entry        i_wdata,
    input  wire  [$clog2(DEPTH)-1:0]     i_raddr,
    output xdl_pkg::t_entry              o_rdata
);

    xdl_pkg::t_entry r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

[rtl/xor_distance_lookup_table.sv]
// Xor-distance lookup shortlist, sequenced over one entry memory and one compare unit.
// Each entry read passes a read state and an evaluate state on the single memory
// read port; get next first runs a trim when one is pending.
// One request at a time; o_busy is high meanwhile.
// The result shows on o_done for one cycle; the receiver cannot stall.
// Synchronous active-low reset empties the table and loads register defaults.
`default_nettype none

module xor_distance_lookup_table #(
    parameter int TABLE_DEPTH = xdl_pkg::TableDepth
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_start,
    output logic        o_busy,
    input  wire  [1:0]  i_action,
    input  wire  [63:0] i_node_id_hi,
    input  wire  [63:0] i_node_id_mid,
    input  wire  [31:0] i_node_id_lo,
    input  wire  [47:0] i_node_address,
    input  wire         i_reply_success,
    input  wire         i_trim_final,
    input  wire         i_cfg_we,
    input  wire  [2:0]  i_cfg_idx,
    input  wire  [63:0] i_cfg_data,
    output logic        o_done,
    output logic [2:0]  o_status,
    output logic [63:0] o_contact_id_hi,
    output logic [63:0] o_contact_id_mid,
    output logic [31:0] o_contact_id_lo,
    output logic [47:0] o_contact_address,
    output logic [3:0]  o_pending_count,
    output logic [15:0] o_contacted_count,
    output logic [15:0] o_replied_count
);

    localparam int IW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int NW = CW + 8;
    localparam logic [CW-1:0] NONE_SLOT = CW'(TABLE_DEPTH);
    localparam logic [CW-1:0] FULL_CNT  = CW'(TABLE_DEPTH);

    typedef enum logic [4:0] {
        S_IDLE, S_ADD_RD, S_ADD_EV, S_ADD_DEC, S_ADD_SH, S_ADD_SHW, S_ADD_INS,
        S_GN_CHK, S_GN_PICK, S_GN_SCAN, S_GN_SEV, S_REP_RD, S_REP_EV,
        S_TRIM_RD, S_TRIM_EV, S_TRIM_END, S_RESP
    } t_state;

    t_state              r_state;
    xdl_pkg::t_id        r_target;
    logic [3:0]          r_conc_limit;
    logic [5:0]          r_closest_keep;
    logic                r_ann_mode;
    logic [3:0]          r_ann_keep;
    xdl_pkg::t_entry     r_new;
    logic                r_success;
    logic [CW-1:0]       r_cnt;
    logic [CW-1:0]       r_next;
    logic [CW-1:0]       r_idx;
    logic [CW-1:0]       r_pos;
    logic [CW-1:0]       r_w;
    logic                r_found;
    logic                r_retrim;
    logic                r_ret;
    logic signed [NW-1:0] r_need_c;
    logic signed [NW-1:0] r_need_g;
    logic [3:0]          r_pend;
    logic [15:0]         r_sent;
    logic [15:0]         r_replied;
    logic [2:0]          r_status;
    xdl_pkg::t_entry     r_out;

    logic                mem_we;
    logic [IW-1:0]       mem_waddr;
    logic [IW-1:0]       mem_raddr;
    xdl_pkg::t_entry     mem_wdata;
    xdl_pkg::t_entry     mem_rdata;
    logic                cmp_closer;
    logic                cmp_equal;
    logic [CW-1:0]       idx_dec;
    logic                rd_act;
    logic                rd_good;
    logic                trim_keep;
    logic [2:0]          rep_st;

    xdl_mem #(.DEPTH(TABLE_DEPTH)) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    xdl_cmp u_cmp (
        .i_a      (r_new.key),
        .i_b      (mem_rdata.key),
        .i_target (r_target),
        .o_closer (cmp_closer),
        .o_equal  (cmp_equal)
    );

    // decode of the fetched entry
    assign idx_dec   = r_idx - 1'b1;
    assign rd_act    = mem_rdata.st[xdl_pkg::BIT_ACTIVE];
    assign rd_good   = mem_rdata.st[xdl_pkg::BIT_GOOD];
    assign trim_keep = rd_act || (r_need_c > 0) || (rd_good && (r_need_g > 0));

    // new status bits of a reported contact
    always_comb begin
        rep_st = mem_rdata.st;
        if (r_success) begin
            rep_st[xdl_pkg::BIT_GOOD] = 1'b1;
            rep_st[xdl_pkg::BIT_BAD]  = 1'b0;
        end else begin
            rep_st[xdl_pkg::BIT_BAD]  = 1'b1;
            rep_st[xdl_pkg::BIT_GOOD] = 1'b0;
        end
        rep_st[xdl_pkg::BIT_ACTIVE] = 1'b0;
    end

    // memory port control per sequencer step
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_idx[IW-1:0];
        mem_wdata = mem_rdata;
        mem_raddr = r_idx[IW-1:0];
        case (r_state)
            S_ADD_SH: begin
                mem_raddr = idx_dec[IW-1:0];
            end
            S_ADD_SHW: begin
                mem_we = 1'b1;
            end
            S_ADD_INS: begin
                mem_we    = 1'b1;
                mem_waddr = r_pos[IW-1:0];
                mem_wdata = r_new;
            end
            S_GN_CHK: begin
                mem_raddr = r_next[IW-1:0];
            end
            S_GN_PICK: begin
                mem_we    = 1'b1;
                mem_waddr = r_next[IW-1:0];
                mem_wdata.st[xdl_pkg::BIT_ACTIVE] = 1'b1;
            end
            S_REP_EV: begin
                mem_we       = cmp_equal && rd_act;
                mem_wdata.st = rep_st;
            end
            S_TRIM_EV: begin
                mem_we    = trim_keep;
                mem_waddr = r_w[IW-1:0];
            end
            default: begin
            end
        endcase
    end

    // sequencer, counters and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_target       <= '0;
            r_conc_limit   <= 4'd3;
            r_closest_keep <= 6'd18;
            r_ann_mode     <= 1'b0;
            r_ann_keep     <= 4'd3;
            r_cnt          <= '0;
            r_next         <= NONE_SLOT;
            r_retrim       <= 1'b0;
            r_pend         <= '0;
            r_sent         <= '0;
            r_replied      <= '0;
        end else begin
            // configuration writes
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    xdl_pkg::CFG_TGT_HI:   r_target.hi    <= i_cfg_data;
                    xdl_pkg::CFG_TGT_MID:  r_target.mid   <= i_cfg_data;
                    xdl_pkg::CFG_TGT_LO:   r_target.lo    <= i_cfg_data[31:0];
                    xdl_pkg::CFG_CONC:     r_conc_limit   <= i_cfg_data[3:0];
                    xdl_pkg::CFG_CLOSEST:  r_closest_keep <= i_cfg_data[5:0];
                    xdl_pkg::CFG_ANN_MODE: r_ann_mode     <= i_cfg_data[0];
                    xdl_pkg::CFG_ANN_KEEP: r_ann_keep     <= i_cfg_data[3:0];
                    default: begin
                    end
                endcase
            end

            case (r_state)
                // accept a request
                S_IDLE: begin
                    if (i_start) begin
                        r_new.key.hi  <= i_node_id_hi;
                        r_new.key.mid <= i_node_id_mid;
                        r_new.key.lo  <= i_node_id_lo;
                        r_new.addr    <= i_node_address;
                        r_new.st      <= '0;
                        r_success     <= i_reply_success;
                        r_out         <= '0;
                        r_status      <= xdl_pkg::STS_OK;
                        r_idx         <= '0;
                        r_pos         <= r_cnt;
                        r_found       <= 1'b0;
                        r_w           <= '0;
                        r_need_g      <= r_ann_mode ? NW'(r_ann_keep) : '0;
                        case (i_action)
                            xdl_pkg::ACT_ADD: begin
                                r_state <= S_ADD_RD;
                            end
                            xdl_pkg::ACT_GET: begin
                                r_need_c <= NW'(r_closest_keep);
                                r_ret    <= 1'b1;
                                if (r_pend >= r_conc_limit) begin
                                    r_status <= xdl_pkg::STS_CONC;
                                    r_state  <= S_RESP;
                                end else if (r_retrim) begin
                                    r_next  <= NONE_SLOT;
                                    r_state <= S_TRIM_RD;
                                end else begin
                                    r_state <= S_GN_CHK;
                                end
                            end
                            xdl_pkg::ACT_REP: begin
                                r_state <= S_REP_RD;
                            end
                            default: begin
                                r_need_c <= i_trim_final ? '0 : NW'(r_closest_keep);
                                r_ret    <= 1'b0;
                                r_next   <= NONE_SLOT;
                                r_state  <= S_TRIM_RD;
                            end
                        endcase
                    end
                end
                // add: scan for duplicate and insert position
                S_ADD_RD: begin
                    r_state <= (r_idx == r_cnt) ? S_ADD_DEC : S_ADD_EV;
                end
                S_ADD_EV: begin
                    if (cmp_equal) begin
                        r_status <= xdl_pkg::STS_DUP;
                        r_state  <= S_RESP;
                    end else begin
                        if (!r_found && cmp_closer) begin
                            r_pos   <= r_idx;
                            r_found <= 1'b1;
                        end
                        r_idx   <= r_idx + 1'b1;
                        r_state <= S_ADD_RD;
                    end
                end
                S_ADD_DEC: begin
                    if (r_cnt == FULL_CNT) begin
                        r_status <= xdl_pkg::STS_FULL;
                        r_state  <= S_RESP;
                    end else begin
                        r_idx   <= r_cnt;
                        r_state <= S_ADD_SH;
                    end
                end
                // add: open a slot by moving entries one place down
                S_ADD_SH: begin
                    r_state <= (r_idx == r_pos) ? S_ADD_INS : S_ADD_SHW;
                end
                S_ADD_SHW: begin
                    r_idx   <= idx_dec;
                    r_state <= S_ADD_SH;
                end
                S_ADD_INS: begin
                    r_cnt    <= r_cnt + 1'b1;
                    r_retrim <= 1'b1;
                    if (r_next != NONE_SLOT && r_next >= r_pos) begin
                        r_next <= r_next + 1'b1;
                    end
                    r_state  <= S_RESP;
                end
                // get next: hand out the marked contact
                S_GN_CHK: begin
                    if (r_next >= r_cnt) begin
                        r_next   <= NONE_SLOT;
                        r_status <= xdl_pkg::STS_NONE;
                        r_state  <= S_RESP;
                    end else begin
                        r_state <= S_GN_PICK;
                    end
                end
                S_GN_PICK: begin
                    r_out.key  <= mem_rdata.key;
                    r_out.addr <= mem_rdata.addr;
                    if (r_pend != 4'hF) begin
                        r_pend <= r_pend + 1'b1;
                    end
                    if (r_sent != 16'hFFFF) begin
                        r_sent <= r_sent + 1'b1;
                    end
                    r_idx   <= r_next + 1'b1;
                    r_state <= S_GN_SCAN;
                end
                // get next: find the following uncontacted entry
                S_GN_SCAN: begin
                    if (r_idx >= r_cnt) begin
                        r_next  <= NONE_SLOT;
                        r_state <= S_RESP;
                    end else begin
                        r_state <= S_GN_SEV;
                    end
                end
                S_GN_SEV: begin
                    if (mem_rdata.st == '0) begin
                        r_next  <= r_idx;
                        r_state <= S_RESP;
                    end else begin
                        r_idx   <= r_idx + 1'b1;
                        r_state <= S_GN_SCAN;
                    end
                end
                // report: look up the id and close its query
                S_REP_RD: begin
                    if (r_idx == r_cnt) begin
                        r_status <= xdl_pkg::STS_NOT_ACT;
                        r_state  <= S_RESP;
                    end else begin
                        r_state <= S_REP_EV;
                    end
                end
                S_REP_EV: begin
                    if (cmp_equal) begin
                        if (!rd_act) begin
                            r_status <= xdl_pkg::STS_NOT_ACT;
                        end else begin
                            if (r_success && r_replied != 16'hFFFF) begin
                                r_replied <= r_replied + 1'b1;
                            end
                            if (r_pend != '0) begin
                                r_pend <= r_pend - 1'b1;
                            end
                        end
                        r_state <= S_RESP;
                    end else begin
                        r_idx   <= r_idx + 1'b1;
                        r_state <= S_REP_RD;
                    end
                end
                // trim: compact kept entries toward slot zero
                S_TRIM_RD: begin
                    r_state <= (r_idx == r_cnt) ? S_TRIM_END : S_TRIM_EV;
                end
                S_TRIM_EV: begin
                    if (trim_keep) begin
                        r_need_c <= r_need_c - 1'b1;
                        if (rd_good) begin
                            r_need_g <= r_need_g - 1'b1;
                        end
                        if (r_next == NONE_SLOT && mem_rdata.st == '0) begin
                            r_next <= r_w;
                        end
                        r_w <= r_w + 1'b1;
                    end
                    r_idx   <= r_idx + 1'b1;
                    r_state <= S_TRIM_RD;
                end
                S_TRIM_END: begin
                    r_cnt    <= r_w;
                    r_retrim <= 1'b0;
                    r_state  <= r_ret ? S_GN_CHK : S_RESP;
                end
                // present the result
                S_RESP: begin
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // result ports
    assign o_busy            = r_state != S_IDLE;
    assign o_done            = r_state == S_RESP;
    assign o_status          = r_status;
    assign o_contact_id_hi   = r_out.key.hi;
    assign o_contact_id_mid  = r_out.key.mid;
    assign o_contact_id_lo   = r_out.key.lo;
    assign o_contact_address = r_out.addr;
    assign o_pending_count   = r_pend;
    assign o_contacted_count = r_sent;
    assign o_replied_count   = r_replied;

endmodule

`default_nettype wire

[verif/testbench.sv]
// Self-checking testbench for the xor-distance lookup shortlist.
// Uses xdl_pkg; a scoreboard class predicts each result and checks the o_done strobes.
// Stimulus: directed corners, then random requests over several register settings.
`default_nettype none

module testbench;

    localparam int Depth = xdl_pkg::TableDepth;
    localparam int CycleLimit = 3000000;

    // one expected or observed result
    typedef struct {
        logic [2:0]  status;
        logic [63:0] hi;
        logic [63:0] mid;
        logic [31:0] lo;
        logic [47:0] addr;
        logic [3:0]  pend;
        logic [15:0] sent;
        logic [15:0] rep;
    } t_res;

    // shortlist predictor and result checker
    class shortlist_scoreboard;
        logic [63:0] tgt_hi, tgt_mid;
        logic [31:0] tgt_lo;
        logic [3:0]  conc_lim;
        logic [5:0]  keep_closest;
        logic        ann_mode;
        logic [3:0]  ann_keep;
        xdl_pkg::t_entry tab [Depth];
        logic        vld [Depth];
        int          nxt;
        logic        retrim;
        logic [3:0]  outq;
        logic [15:0] sent, rep;
        t_res        awaited [$];
        xdl_pkg::t_id handed [$];
        int          errors;

        function new();
            tgt_hi = '0; tgt_mid = '0; tgt_lo = '0;
            conc_lim = 4'd3; keep_closest = 6'd18; ann_mode = 1'b0; ann_keep = 4'd3;
            foreach (vld[i]) begin
                vld[i] = 1'b0;
                tab[i] = '0;
            end
            nxt = Depth; retrim = 1'b0; outq = '0; sent = '0; rep = '0;
            errors = 0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [63:0] d);
            case (idx)
                xdl_pkg::CFG_TGT_HI:   tgt_hi = d;
                xdl_pkg::CFG_TGT_MID:  tgt_mid = d;
                xdl_pkg::CFG_TGT_LO:   tgt_lo = d[31:0];
                xdl_pkg::CFG_CONC:     conc_lim = d[3:0];
                xdl_pkg::CFG_CLOSEST:  keep_closest = d[5:0];
                xdl_pkg::CFG_ANN_MODE: ann_mode = d[0];
                xdl_pkg::CFG_ANN_KEEP: ann_keep = d[3:0];
                default: ;
            endcase
        endfunction

        function int used();
            int n;
            n = 0;
            while (n < Depth && vld[n]) n++;
            return n;
        endfunction

        // strictly closer to the target by xor distance
        function bit closer(xdl_pkg::t_id a, xdl_pkg::t_id b);
            logic [159:0] t;
            t = {tgt_hi, tgt_mid, tgt_lo};
            return (a ^ t) < (b ^ t);
        endfunction

        function int find(int cnt, xdl_pkg::t_id k);
            for (int i = 0; i < cnt; i++)
                if (tab[i].key == k) return i;
            return Depth;
        endfunction

        function void prune(bit fin);
            int cnt, w, need_c, need_g;
            logic [2:0] st;
            cnt = used();
            w = 0;
            need_c = fin ? 0 : int'(keep_closest);
            need_g = ann_mode ? int'(ann_keep) : 0;
            nxt = Depth;
            for (int r = 0; r < cnt; r++) begin
                st = tab[r].st;
                if (!st[xdl_pkg::BIT_ACTIVE] && need_c <= 0 &&
                    (!st[xdl_pkg::BIT_GOOD] || need_g <= 0))
                    continue;
                need_c--;
                if (st[xdl_pkg::BIT_GOOD]) need_g--;
                tab[w] = tab[r];
                vld[w] = vld[r];
                if (nxt == Depth && st == 3'b000) nxt = w;
                w++;
            end
            for (int r = w; r < cnt; r++) vld[r] = 1'b0;
            retrim = 1'b0;
        endfunction

        // predict the result of one accepted request
        function void note(logic [1:0] act, xdl_pkg::t_id k, logic [47:0] a, bit ok, bit fin);
            t_res e;
            int cnt, pos, s, i;
            e = '{default: '0};
            e.status = xdl_pkg::STS_OK;
            cnt = used();
            case (act)
                xdl_pkg::ACT_ADD: begin
                    if (find(cnt, k) != Depth) e.status = xdl_pkg::STS_DUP;
                    else if (cnt >= Depth) e.status = xdl_pkg::STS_FULL;
                    else begin
                        pos = 0;
                        while (pos < cnt && !closer(k, tab[pos].key)) pos++;
                        for (i = cnt; i > pos; i--) begin
                            tab[i] = tab[i-1];
                            vld[i] = vld[i-1];
                        end
                        tab[pos].key = k; tab[pos].addr = a; tab[pos].st = '0;
                        vld[pos] = 1'b1;
                        if (nxt != Depth && nxt >= pos) nxt++;
                        retrim = 1'b1;
                    end
                end
                xdl_pkg::ACT_GET: begin
                    if (outq >= conc_lim) e.status = xdl_pkg::STS_CONC;
                    else begin
                        if (retrim) begin
                            prune(1'b0);
                            cnt = used();
                        end
                        if (nxt >= cnt) begin
                            nxt = Depth;
                            e.status = xdl_pkg::STS_NONE;
                        end else begin
                            s = nxt;
                            tab[s].st[xdl_pkg::BIT_ACTIVE] = 1'b1;
                            if (outq < 4'd15) outq++;
                            if (sent != 16'hffff) sent++;
                            e.hi = tab[s].key.hi; e.mid = tab[s].key.mid;
                            e.lo = tab[s].key.lo; e.addr = tab[s].addr;
                            handed.push_back(tab[s].key);
                            for (i = s + 1; i < cnt; i++)
                                if (tab[i].st == 3'b000) break;
                            nxt = (i < cnt) ? i : Depth;
                        end
                    end
                end
                xdl_pkg::ACT_REP: begin
                    s = find(cnt, k);
                    if (s == Depth || !tab[s].st[xdl_pkg::BIT_ACTIVE])
                        e.status = xdl_pkg::STS_NOT_ACT;
                    else begin
                        if (ok) begin
                            tab[s].st[xdl_pkg::BIT_GOOD] = 1'b1;
                            tab[s].st[xdl_pkg::BIT_BAD] = 1'b0;
                            if (rep != 16'hffff) rep++;
                        end else begin
                            tab[s].st[xdl_pkg::BIT_BAD] = 1'b1;
                            tab[s].st[xdl_pkg::BIT_GOOD] = 1'b0;
                        end
                        tab[s].st[xdl_pkg::BIT_ACTIVE] = 1'b0;
                        if (outq > 0) outq--;
                    end
                end
                default: prune(fin);
            endcase
            e.pend = outq; e.sent = sent; e.rep = rep;
            awaited.push_back(e);
        endfunction

        function void field(string name, logic [63:0] exp_v, logic [63:0] got_v);
            if (exp_v !== got_v) begin
                $error("%s: expected %h, got %h", name, exp_v, got_v);
                errors++;
            end
        endfunction

        function void check(t_res g);
            t_res e;
            if (awaited.size() == 0) begin
                $error("result with no request outstanding");
                errors++;
                return;
            end
            e = awaited.pop_front();
            field("status", 64'(e.status), 64'(g.status));
            field("contact_id_hi", e.hi, g.hi);
            field("contact_id_mid", e.mid, g.mid);
            field("contact_id_lo", 64'(e.lo), 64'(g.lo));
            field("contact_address", 64'(e.addr), 64'(g.addr));
            field("pending_count", 64'(e.pend), 64'(g.pend));
            field("contacted_count", 64'(e.sent), 64'(g.sent));
            field("replied_count", 64'(e.rep), 64'(g.rep));
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_start = 1'b0;
    logic [1:0]  i_action = xdl_pkg::ACT_ADD;
    logic [63:0] i_node_id_hi = '0;
    logic [63:0] i_node_id_mid = '0;
    logic [31:0] i_node_id_lo = '0;
    logic [47:0] i_node_address = '0;
    logic        i_reply_success = 1'b0;
    logic        i_trim_final = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_idx = xdl_pkg::CFG_TGT_HI;
    logic [63:0] i_cfg_data = '0;
    logic        o_busy, o_done;
    logic [2:0]  o_status;
    logic [63:0] o_contact_id_hi, o_contact_id_mid;
    logic [31:0] o_contact_id_lo;
    logic [47:0] o_contact_address;
    logic [3:0]  o_pending_count;
    logic [15:0] o_contacted_count, o_replied_count;

    shortlist_scoreboard sb = new();
    xdl_pkg::t_id id_pool [$];
    int   gap_pct;
    int   cycles;

    xor_distance_lookup_table dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .o_busy(o_busy),
        .i_action(i_action), .i_node_id_hi(i_node_id_hi), .i_node_id_mid(i_node_id_mid),
        .i_node_id_lo(i_node_id_lo), .i_node_address(i_node_address),
        .i_reply_success(i_reply_success), .i_trim_final(i_trim_final),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .o_done(o_done), .o_status(o_status), .o_contact_id_hi(o_contact_id_hi),
        .o_contact_id_mid(o_contact_id_mid), .o_contact_id_lo(o_contact_id_lo),
        .o_contact_address(o_contact_address), .o_pending_count(o_pending_count),
        .o_contacted_count(o_contacted_count), .o_replied_count(o_replied_count)
    );

    // clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // check results, then note accepted requests; watchdog
    always @(posedge i_clk) begin
        t_res g;
        cycles++;
        if (cycles > CycleLimit) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
        if (i_rst_n && o_done) begin
            g.status = o_status; g.hi = o_contact_id_hi; g.mid = o_contact_id_mid;
            g.lo = o_contact_id_lo; g.addr = o_contact_address; g.pend = o_pending_count;
            g.sent = o_contacted_count; g.rep = o_replied_count;
            sb.check(g);
        end
        if (i_rst_n && i_start && !o_busy)
            sb.note(i_action, '{hi: i_node_id_hi, mid: i_node_id_mid, lo: i_node_id_lo},
                    i_node_address, i_reply_success, i_trim_final);
    end

    // register write, called at a falling edge while idle
    task automatic cfg_write(logic [2:0] idx, logic [63:0] d);
        i_cfg_we = 1'b1;
        i_cfg_idx = idx;
        i_cfg_data = d;
        sb.set_reg(idx, d);
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    // hold until every expected result is back and the block is idle
    task automatic drain();
        i_start = 1'b0;
        while (sb.awaited.size() != 0 || o_busy) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // one request; returns at the falling edge after acceptance, or after a random idle gap
    task automatic send_req(logic [1:0] act, xdl_pkg::t_id k, logic [47:0] a, bit ok,
                            bit fin);
        bit taken;
        i_action = act;
        i_node_id_hi = k.hi; i_node_id_mid = k.mid; i_node_id_lo = k.lo;
        i_node_address = a; i_reply_success = ok; i_trim_final = fin;
        i_start = 1'b1;
        taken = 1'b0;
        while (!taken) begin
            @(posedge i_clk);
            taken = !o_busy;
        end
        @(negedge i_clk);
        if ($urandom_range(99) < gap_pct) begin
            i_start = 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge i_clk);
        end
    endtask

    function automatic logic [63:0] rnd64();
        return {$urandom, $urandom};
    endfunction

    // new id: random, or sharing a prefix with the target to reach the low compares
    function automatic xdl_pkg::t_id fresh_id();
        xdl_pkg::t_id k;
        k.hi = rnd64(); k.mid = rnd64(); k.lo = $urandom;
        case ($urandom_range(5))
            0: k.hi = sb.tgt_hi ^ {60'd0, 4'($urandom)};
            1: begin
                k.hi = sb.tgt_hi;
                k.mid = sb.tgt_mid ^ {56'd0, 8'($urandom)};
            end
            2: begin
                k.hi = sb.tgt_hi;
                k.mid = sb.tgt_mid;
            end
            default: ;
        endcase
        return k;
    endfunction

    // random requests for one phase
    task automatic run_phase(int n, int add_w);
        int r, sel;
        xdl_pkg::t_id k;
        for (int it = 0; it < n; it++) begin
            if ($urandom_range(99) < 3) drain();
            r = $urandom_range(99);
            k = fresh_id();
            if (r < add_w) begin
                if (id_pool.size() != 0 && $urandom_range(9) < 2)
                    k = id_pool[$urandom_range(id_pool.size() - 1)];
                else begin
                    id_pool.push_back(k);
                    if (id_pool.size() > 80) void'(id_pool.pop_front());
                end
                send_req(xdl_pkg::ACT_ADD, k, {$urandom, 16'($urandom)}, 1'($urandom),
                         1'($urandom));
            end else if (r < add_w + (100 - add_w) / 2) begin
                send_req(xdl_pkg::ACT_GET, k, {$urandom, 16'($urandom)}, 1'($urandom),
                         1'($urandom));
            end else if (r < 94) begin
                sel = $urandom_range(9);
                if (sb.handed.size() != 0 && sel < 7) begin
                    sel = $urandom_range(sb.handed.size() - 1);
                    k = sb.handed[sel];
                    sb.handed.delete(sel);
                end else if (id_pool.size() != 0 && sel < 9)
                    k = id_pool[$urandom_range(id_pool.size() - 1)];
                send_req(xdl_pkg::ACT_REP, k, {$urandom, 16'($urandom)}, 1'($urandom),
                         1'($urandom));
            end else begin
                send_req(xdl_pkg::ACT_TRIM, k, {$urandom, 16'($urandom)}, 1'($urandom),
                         $urandom_range(9) < 3);
            end
        end
    endtask

    // register settings per phase: random target, conc, closest, ann mode, ann keep
    task automatic configure(int conc, int keep, int am, int ak);
        cfg_write(xdl_pkg::CFG_TGT_HI, rnd64());
        cfg_write(xdl_pkg::CFG_TGT_MID, rnd64());
        cfg_write(xdl_pkg::CFG_TGT_LO, {32'd0, $urandom});
        cfg_write(xdl_pkg::CFG_CONC, 64'(conc));
        cfg_write(xdl_pkg::CFG_CLOSEST, 64'(keep));
        cfg_write(xdl_pkg::CFG_ANN_MODE, 64'(am));
        cfg_write(xdl_pkg::CFG_ANN_KEEP, 64'(ak));
    endtask

    initial begin
        xdl_pkg::t_id zero_id, ones_id, other_id;
        cycles = 0;
        gap_pct = 0;
        zero_id = '0;
        ones_id = '1;
        other_id = '{hi: 64'h8000_0000_0000_0000, mid: '0, lo: 32'h1};
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // directed corners at register defaults
        send_req(xdl_pkg::ACT_ADD, zero_id, '0, 1'b0, 1'b0);
        send_req(xdl_pkg::ACT_ADD, ones_id, '1, 1'b1, 1'b1);
        send_req(xdl_pkg::ACT_ADD, zero_id, 48'h1234, 1'b0, 1'b0);
        send_req(xdl_pkg::ACT_ADD, other_id, 48'h8000_0000_0001, 1'b0, 1'b0);
        send_req(xdl_pkg::ACT_GET, zero_id, '0, 1'b0, 1'b0);
        send_req(xdl_pkg::ACT_GET, zero_id, '0, 1'b0, 1'b0);
        send_req(xdl_pkg::ACT_GET, zero_id, '0, 1'b0, 1'b0);
        send_req(xdl_pkg::ACT_GET, zero_id, '0, 1'b0, 1'b0);
        send_req(xdl_pkg::ACT_REP, zero_id, '0, 1'b1, 1'b0);
        send_req(xdl_pkg::ACT_REP, ones_id, '1, 1'b0, 1'b1);
        send_req(xdl_pkg::ACT_REP, zero_id, '0, 1'b1, 1'b0);
        send_req(xdl_pkg::ACT_REP, fresh_id(), '0, 1'b1, 1'b0);
        send_req(xdl_pkg::ACT_GET, zero_id, '0, 1'b0, 1'b0);
        send_req(xdl_pkg::ACT_TRIM, zero_id, '0, 1'b0, 1'b0);
        send_req(xdl_pkg::ACT_REP, other_id, '0, 1'b1, 1'b0);
        send_req(xdl_pkg::ACT_TRIM, ones_id, '1, 1'b1, 1'b1);
        send_req(xdl_pkg::ACT_GET, zero_id, '0, 1'b0, 1'b0);
        sb.handed.delete();
        drain();

        // random phases over register settings and sender gaps
        configure(3, 18, 0, 3);   gap_pct = 0;  run_phase(250, 45);
        drain(); configure(1, 1, 1, 0);    gap_pct = 55; run_phase(250, 45);
        drain(); configure(8, 32, 1, 8);   gap_pct = 18; run_phase(250, 50);
        drain(); configure(0, 63, 0, 15);  gap_pct = 0;  run_phase(200, 85);
        drain(); configure(15, 0, 1, 15);  gap_pct = 55; run_phase(200, 45);
        drain(); configure(2, 6, 1, 2);    gap_pct = 18; run_phase(300, 45);
        drain(); configure(4, 40, 0, 1);   gap_pct = 0;  run_phase(300, 55);

        drain();
        repeat (20) @(negedge i_clk);
        if (sb.errors == 0 && sb.awaited.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            if (sb.awaited.size() != 0) $error("%0d results never came", sb.awaited.size());
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

`default_nettype wire
